// ===== sv/egsd_pkg.sv =====
// ============================================================================
// egsd_pkg
// Shared types and constants for the exp-golomb stream decoder
// ============================================================================
package egsd_pkg;

    localparam int MAX_PREFIX_DEF = 31;   // longest legal zero prefix
    localparam int PLEN_W         = 6;    // prefix length / suffix counter width
    localparam int CODE_W         = 32;   // decoded value width
    localparam int BYTE_W         = 8;
    localparam int BIT_CNT_W      = 3;    // bit position within a byte
    localparam int ZRUN_W         = 2;

    localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h03;
    localparam logic [ZRUN_W-1:0] ZRUN_SAT  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BITS,
        ST_FLUSH
    } egsd_state_t;

    // sequencer to shared bit unit and output stage
    typedef struct packed {
        logic step;      // consume one bit this cycle
        logic clear;     // start of unit, clear decoder state
        logic bit_in;    // current stream bit, msb first
        logic idle;      // sequencer waits for an item
        logic flush;     // hand the held result over as the last of its byte
    } egsd_ctrl_t;

    // output stage back to the sequencer
    typedef struct packed {
        logic emit;        // current bit finishes a code
        logic pend_valid;  // a finished result is held back
        logic out_free;    // output register can take a result
    } egsd_stat_t;

    // one finished code
    typedef struct packed {
        logic              emit;
        logic              err;
        logic [CODE_W-1:0] uval;
        logic [CODE_W-1:0] sval;
    } egsd_res_t;

endpackage

// ===== sv/exp_golomb_stream_decoder.sv =====
// ============================================================================
// exp_golomb_stream_decoder
// Order-0 exp-golomb ue/se decoder on a byte stream with escape removal
// ============================================================================
// Takes one stream byte per input item and decodes its bits msb first, one
// bit per clock unless stalled, as back-to-back order-0 exp-golomb codes; each
// finished code leaves as one output item with its ue value, its se mapping,
// a prefix error flag (tuser) and a last-in-byte mark (tlast). With cfg escape
// removal on, a 0x03 byte after two or more zero bytes is dropped and gives no
// items. tuser high on an input item clears the zero run and any partly read
// code. An accepted byte is taken while the sequencer is idle, its eight bits
// are then stepped through the shared bit unit, and its final result, if it
// has any, is handed over in a flush state; a dropped escape byte is only
// accepted. No byte is taken before the last is through. A finished result
// is held back one code so that tlast can be set; a bit cycle that finishes
// a code stalls while that held result cannot enter the output register.
module exp_golomb_stream_decoder #(
    parameter int MAX_PREFIX = egsd_pkg::MAX_PREFIX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration: escape_removal_enable
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [egsd_pkg::BYTE_W-1:0]    s_tdata,    // [7:0] data_byte
    input  logic                           s_tuser,    // [0] start_of_unit
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [2*egsd_pkg::CODE_W-1:0]  m_tdata,    // [31:0] unsigned_value,
                                                       // [63:32] signed_value
    output logic                           m_tuser,    // [0] prefix_error
    output logic                           m_tlast     // last_in_byte
);
    import egsd_pkg::*;

    // escape removal enable, on after reset
    logic              esc_en_reg;

    egsd_ctrl_t        ctrl;
    egsd_stat_t        stat;
    egsd_res_t         res;

    // held-back result, waiting to learn whether it closes its byte
    logic              pend_valid_reg, pend_valid_next;
    logic [CODE_W-1:0] pend_uval_reg;
    logic [CODE_W-1:0] pend_sval_reg;
    logic              pend_err_reg;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [CODE_W-1:0] out_uval_reg;
    logic [CODE_W-1:0] out_sval_reg;
    logic              out_err_reg;
    logic              out_last_reg;

    logic              out_free;
    logic              push_step;
    logic              out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            esc_en_reg <= 1'b1;
        else if (cfg_we)
            esc_en_reg <= cfg_wdata;
    end

    egsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .esc_en   (esc_en_reg),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    egsd_bit_unit #(
        .MAX_PREFIX (MAX_PREFIX)
    ) u_bit_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .res   (res)
    );

    assign out_free        = !out_valid_reg || m_tready;
    assign stat.emit       = res.emit;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = out_free;

    // a new code pushes the held one out as not last; flush sends it as last
    assign push_step = ctrl.step && res.emit;
    assign out_load  = (push_step && pend_valid_reg) || ctrl.flush;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (push_step)
            pend_valid_next = 1'b1;
        else if (ctrl.flush)
            pend_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_uval_reg <= pend_uval_reg;
            out_sval_reg <= pend_sval_reg;
            out_err_reg  <= pend_err_reg;
            out_last_reg <= ctrl.flush;
        end
        if (push_step)
        begin
            pend_uval_reg <= res.uval;
            pend_sval_reg <= res.sval;
            pend_err_reg  <= res.err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_sval_reg, out_uval_reg};
    assign m_tuser  = out_err_reg;
    assign m_tlast  = out_last_reg;

    // nothing is held back once the sequencer waits for the next byte
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.idle |-> !pend_valid_reg)
        else $error("result held back while sequencer idle");

    // a code never finishes while the held result is stuck behind a full output
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (push_step && pend_valid_reg) |-> out_free)
        else $error("held result overwritten");

    // a flush always shows up as the last item of its byte
    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.flush |=> (m_tvalid && m_tlast))
        else $error("flush did not present a last item");

endmodule

// ===== sv/egsd_bit_unit.sv =====
// ============================================================================
// egsd_bit_unit
// Shared one-bit exp-golomb decode step with its code state
// ============================================================================
module egsd_bit_unit #(
    parameter int MAX_PREFIX = egsd_pkg::MAX_PREFIX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  egsd_pkg::egsd_ctrl_t ctrl,
    output egsd_pkg::egsd_res_t  res
);
    import egsd_pkg::*;

    logic              reading_reg, reading_next;
    logic [PLEN_W-1:0] plen_reg, plen_next;
    logic [PLEN_W-1:0] srem_reg, srem_next;
    logic [CODE_W-1:0] accum_reg, accum_next;

    logic [PLEN_W-1:0] plen_inc;
    logic [CODE_W-1:0] word;       // leading one followed by the suffix
    logic [CODE_W-1:0] half;
    logic              emit;
    logic              err;

    assign plen_inc = plen_reg + PLEN_W'(1);

    // code word w = 2^len + suffix, ue = w - 1
    always_comb
    begin
        emit         = 1'b0;
        err          = 1'b0;
        word         = '0;
        reading_next = reading_reg;
        plen_next    = plen_reg;
        srem_next    = srem_reg;
        accum_next   = accum_reg;

        if (!reading_reg)
        begin
            if (!ctrl.bit_in)
            begin
                plen_next = plen_inc;
                if (plen_inc > PLEN_W'(MAX_PREFIX))
                begin
                    emit      = 1'b1;
                    err       = 1'b1;
                    plen_next = '0;
                end
            end
            else if (plen_reg == '0)
            begin
                emit = 1'b1;
                word = CODE_W'(1);
            end
            else
            begin
                reading_next = 1'b1;
                srem_next    = plen_reg;
                accum_next   = CODE_W'(1);
            end
        end
        else
        begin
            accum_next = {accum_reg[CODE_W-2:0], ctrl.bit_in};
            srem_next  = srem_reg - PLEN_W'(1);
            if (srem_reg == PLEN_W'(1))
            begin
                emit         = 1'b1;
                word         = accum_next;
                reading_next = 1'b0;
                plen_next    = '0;
                srem_next    = '0;
                accum_next   = '0;
            end
        end
    end

    assign half = {1'b0, word[CODE_W-1:1]};

    always_comb
    begin
        res.emit = emit;
        res.err  = err;
        if (err)
        begin
            res.uval = '0;
            res.sval = '0;
        end
        else
        begin
            res.uval = word - CODE_W'(1);
            res.sval = word[0] ? (CODE_W'(0) - half) : half;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reading_reg <= 1'b0;
            plen_reg    <= '0;
            srem_reg    <= '0;
            accum_reg   <= '0;
        end
        else if (ctrl.clear)
        begin
            reading_reg <= 1'b0;
            plen_reg    <= '0;
            srem_reg    <= '0;
            accum_reg   <= '0;
        end
        else if (ctrl.step)
        begin
            reading_reg <= reading_next;
            plen_reg    <= plen_next;
            srem_reg    <= srem_next;
            accum_reg   <= accum_next;
        end
    end

endmodule

// ===== sv/egsd_ctrl.sv =====
// ============================================================================
// egsd_ctrl
// Byte sequencer: escape removal, zero run tracking, bit stepping
// ============================================================================
module egsd_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [egsd_pkg::BYTE_W-1:0]  s_tdata,
    input  logic                         s_tuser,
    input  logic                         esc_en,
    input  egsd_pkg::egsd_stat_t         stat,
    output egsd_pkg::egsd_ctrl_t         ctrl
);
    import egsd_pkg::*;

    egsd_state_t          state_reg, state_next;
    logic [BIT_CNT_W-1:0] cnt_reg;
    logic [BYTE_W-1:0]    byte_reg;
    logic [ZRUN_W-1:0]    zrun_reg;

    logic                 accept;
    logic                 drop;
    logic                 fire;
    logic                 last_step;
    logic [ZRUN_W-1:0]    zrun_eff;

    assign accept    = (state_reg == ST_IDLE) && s_tvalid;
    assign zrun_eff  = s_tuser ? '0 : zrun_reg;
    assign drop      = esc_en && (zrun_eff == ZRUN_SAT) && (s_tdata == ESC_BYTE);
    // a bit that finishes a code waits while the held result cannot move on
    assign fire      = (state_reg == ST_BITS)
                       && (!stat.emit || !stat.pend_valid || stat.out_free);
    assign last_step = fire && (cnt_reg == {BIT_CNT_W{1'b1}});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !drop)
                    state_next = ST_BITS;
            end
            ST_BITS:
            begin
                if (last_step)
                    state_next = (stat.pend_valid || stat.emit) ? ST_FLUSH : ST_IDLE;
            end
            ST_FLUSH:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready    = 1'b0;
        ctrl.step   = 1'b0;
        ctrl.clear  = 1'b0;
        ctrl.flush  = 1'b0;
        ctrl.idle   = 1'b0;
        ctrl.bit_in = byte_reg[BYTE_W-1];
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                ctrl.idle  = 1'b1;
                ctrl.clear = accept && s_tuser;
            end
            ST_BITS:
            begin
                ctrl.step = fire;
            end
            ST_FLUSH:
            begin
                ctrl.flush = stat.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            zrun_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= '0;
                if (drop || (s_tdata != '0))
                    zrun_reg <= '0;
                else if (zrun_eff == ZRUN_SAT)
                    zrun_reg <= ZRUN_SAT;
                else
                    zrun_reg <= zrun_eff + ZRUN_W'(1);
            end
            else if (fire)
            begin
                cnt_reg <= cnt_reg + BIT_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            byte_reg <= s_tdata;
        else if (fire)
            byte_reg <= {byte_reg[BYTE_W-2:0], 1'b0};
    end

endmodule

// ===== sim/exp_golomb_stream_decoder_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// exp_golomb_stream_decoder_tb
// Self-checking testbench for the exp-golomb stream decoder
// ============================================================================
// Feeds stream bytes through the input stream port and predicts the decoded
// codes with a behavioral decoder in the bench, or takes them from a directed
// row. A short table of directed bytes comes first (all-ones byte, long zero
// prefixes, prefix error, dropped escape byte, largest code, removal off),
// then random units of well-formed codes mixed with noise and broken escape
// sequences, over both settings of the escape removal register. The sender
// runs in random bursts, the receiver stalls on its own patterns, with one
// long receiver hold-off and one full drain in the middle of a phase.
// ============================================================================
module exp_golomb_stream_decoder_tb;

    import egsd_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int SETTLE_CYC   = 20;        // more than one byte of bit cycles
    localparam int HOLD_CYC     = 300;       // long receiver hold-off
    localparam int PHASE_ITEMS  = 36;
    localparam int N_PHASES     = 8;
    localparam int TIMEOUT_NS   = 2_000_000;

    // one decoded code as seen on the result port
    typedef struct packed {
        logic [CODE_W-1:0] unsigned_value;
        logic [CODE_W-1:0] signed_value;
        logic              prefix_error;
        logic              last_in_byte;
    } egsd_code_t;

    // directed byte with an optional hand-written expectation
    typedef struct packed {
        logic [7:0]        data;
        logic              sou;
        logic              esc;      // escape removal setting for this byte
        logic              typed;    // expectation below is used as is
        logic [3:0]        cnt;      // number of codes, all equal
        logic [CODE_W-1:0] uval;
        logic [CODE_W-1:0] sval;
        logic              err;
    } dir_row_t;

    localparam int DIR_N = 28;
    localparam dir_row_t DIR_TABLE [DIR_N] = '{
        // all ones after reset: eight one-bit codes
        '{8'hFF, 1'b1, 1'b1, 1'b1, 4'd8, 32'h0, 32'h0, 1'b0},
        // three zero bytes, escape dropped, then the 32nd zero trips the error
        '{8'h00, 1'b1, 1'b1, 1'b1, 4'd0, 32'h0, 32'h0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 4'd0, 32'h0, 32'h0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 4'd0, 32'h0, 32'h0, 1'b0},
        '{8'h03, 1'b0, 1'b1, 1'b1, 4'd0, 32'h0, 32'h0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 4'd1, 32'h0, 32'h0, 1'b1},
        // short code then an unfinished prefix, discarded by start of unit
        '{8'h40, 1'b1, 1'b1, 1'b0, 4'd0, 32'h0, 32'h0, 1'b0},
        // 31 zeros, a one and 31 suffix ones: the largest unsigned value
        '{8'h00, 1'b1, 1'b1, 1'b1, 4'd0, 32'h0, 32'h0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 4'd0, 32'h0, 32'h0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 4'd0, 32'h0, 32'h0, 1'b0},
        '{8'h01, 1'b0, 1'b1, 1'b1, 4'd0, 32'h0, 32'h0, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 1'b1, 4'd0, 32'h0, 32'h0, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 1'b1, 4'd0, 32'h0, 32'h0, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 1'b1, 4'd0, 32'h0, 32'h0, 1'b0},
        '{8'hFE, 1'b0, 1'b1, 1'b1, 4'd1, 32'hFFFF_FFFE, 32'h8000_0001, 1'b0},
        '{8'h80, 1'b1, 1'b1, 1'b1, 4'd1, 32'h0, 32'h0, 1'b0},
        // removal off: the escape byte goes to the decoder
        '{8'h00, 1'b1, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0, 1'b0},
        '{8'h03, 1'b0, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0, 1'b0},
        '{8'h7F, 1'b0, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0, 1'b0},
        // removal on: saturated zero run, escape dropped, next 0x03 decoded
        '{8'h00, 1'b1, 1'b1, 1'b0, 4'd0, 32'h0, 32'h0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 4'd0, 32'h0, 32'h0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 4'd0, 32'h0, 32'h0, 1'b0},
        '{8'h03, 1'b0, 1'b1, 1'b0, 4'd0, 32'h0, 32'h0, 1'b0},
        '{8'h03, 1'b0, 1'b1, 1'b0, 4'd0, 32'h0, 32'h0, 1'b0},
        // start of unit clears the zero run, so this 0x03 is decoded
        '{8'h00, 1'b0, 1'b1, 1'b0, 4'd0, 32'h0, 32'h0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 4'd0, 32'h0, 32'h0, 1'b0},
        '{8'h03, 1'b1, 1'b1, 1'b0, 4'd0, 32'h0, 32'h0, 1'b0}
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_wdata = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata   = '0;     // [7:0] data_byte
    logic                  s_tuser   = 1'b0;   // [0] start_of_unit
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [2*CODE_W-1:0]   m_tdata;            // [31:0] unsigned, [63:32] signed
    logic                  m_tuser;            // [0] prefix_error
    logic                  m_tlast;            // last_in_byte

    // decoder state mirrored by the bench
    logic                  esc_on    = 1'b1;
    logic [ZRUN_W-1:0]     zrun      = '0;
    logic                  rd_suffix = 1'b0;
    logic [PLEN_W-1:0]     plen      = '0;
    logic [PLEN_W-1:0]     srem      = '0;
    logic [CODE_W-1:0]     sacc      = '0;

    egsd_code_t            expected_codes [$];
    int                    n_mismatch = 0;
    int                    n_fed      = 0;     // bytes that reached the decoder
    int                    burst_left = 0;
    int                    gap_max    = 6;
    bit                    hold_req   = 1'b0;

    exp_golomb_stream_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // decoder prediction
    // ------------------------------------------------------------------------
    function automatic void clear_code();
        rd_suffix = 1'b0;
        plen      = '0;
        srem      = '0;
        sacc      = '0;
    endfunction

    // ue value 2^len - 1 + suffix and its se mapping
    function automatic egsd_code_t make_code(input int len, input logic [CODE_W-1:0] sfx);
        egsd_code_t   c;
        logic [63:0]  full;
        full               = (64'd1 << len) - 64'd1 + {32'd0, sfx};
        c.unsigned_value   = full[CODE_W-1:0];
        c.signed_value     = c.unsigned_value[0] ? (c.unsigned_value >> 1) + 32'd1
                                                 : 32'd0 - (c.unsigned_value >> 1);
        c.prefix_error     = 1'b0;
        c.last_in_byte     = 1'b0;
        return c;
    endfunction

    // returns -1 for a dropped escape byte, else the number of codes
    function automatic int decode_byte(input logic [7:0] din, input logic sou,
                                       input bit record);
        egsd_code_t res [8];
        int         n;
        logic       b_now;
        n = 0;
        if (sou)
        begin
            zrun = '0;
            clear_code();
        end
        if (esc_on && zrun >= ZRUN_SAT && din == ESC_BYTE)
        begin
            zrun = '0;
            return -1;
        end
        if (din == 8'h00)
            zrun = (zrun >= ZRUN_SAT) ? ZRUN_SAT : zrun + 2'd1;
        else
            zrun = '0;

        for (int i = 7; i >= 0; i--)
        begin
            b_now = din[i];
            if (!rd_suffix)
            begin
                if (!b_now)
                begin
                    plen = plen + 6'd1;
                    if (int'(plen) > MAX_PREFIX_DEF)
                    begin
                        // error result carries zero values
                        res[n] = '{unsigned_value: '0, signed_value: '0,
                                   prefix_error: 1'b1, last_in_byte: 1'b0};
                        n++;
                        clear_code();
                    end
                end
                else if (plen == 0)
                begin
                    res[n] = make_code(0, '0);
                    n++;
                end
                else
                begin
                    rd_suffix = 1'b1;
                    srem      = plen;
                    sacc      = '0;
                end
            end
            else
            begin
                sacc = {sacc[CODE_W-2:0], b_now};
                srem = srem - 6'd1;
                if (srem == 0)
                begin
                    res[n] = make_code(int'(plen), sacc);
                    n++;
                    clear_code();
                end
            end
        end

        if (record)
            for (int k = 0; k < n; k++)
            begin
                res[k].last_in_byte = (k == n - 1);
                expected_codes.push_back(res[k]);
            end
        return n;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [CODE_W-1:0] got,
                                   input logic [CODE_W-1:0] want);
        $display("%0t: mismatch on %s, got %h, expected %h", $time, what, got, want);
        n_mismatch++;
    endtask

    always @(posedge clk)
    begin : check_results
        egsd_code_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_codes.size() == 0)
                report_mismatch("unexpected item", m_tdata[CODE_W-1:0], '0);
            else
            begin
                e = expected_codes.pop_front();
                if (m_tdata[CODE_W-1:0] !== e.unsigned_value)
                    report_mismatch("unsigned_value", m_tdata[CODE_W-1:0],
                                    e.unsigned_value);
                if (m_tdata[2*CODE_W-1:CODE_W] !== e.signed_value)
                    report_mismatch("signed_value", m_tdata[2*CODE_W-1:CODE_W],
                                    e.signed_value);
                if (m_tuser !== e.prefix_error)
                    report_mismatch("prefix_error", {31'd0, m_tuser},
                                    {31'd0, e.prefix_error});
                if (m_tlast !== e.last_in_byte)
                    report_mismatch("last_in_byte", {31'd0, m_tlast},
                                    {31'd0, e.last_in_byte});
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: stall modes of its own, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int         mode_left;
        int         mode;
        logic [7:0] stall_pat;
        int         pat_idx;
        mode_left = 0;
        mode      = 0;
        stall_pat = 8'hFF;
        pat_idx   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // keep the output blocked so the block backs up into its input
                m_tready <= 1'b0;
                repeat (HOLD_CYC) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                    stall_pat = $urandom_range(0, 255) | 8'h01;
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    default: m_tready <= stall_pat[pat_idx % 8];
                endcase
                pat_idx++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------
    // offer one byte at the falling edge, predict on the accepting rising edge
    task automatic send_item(input logic [7:0] d, input logic sou, input dir_row_t row);
        int gap;
        int n;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= sou;
        do
            @(posedge clk);
        while (!s_tready);
        n = decode_byte(d, sou, !row.typed);
        if (row.typed)
            for (int k = 0; k < int'(row.cnt); k++)
                expected_codes.push_back('{unsigned_value: row.uval,
                                           signed_value: row.sval,
                                           prefix_error: row.err,
                                           last_in_byte: (k == int'(row.cnt) - 1)});
        if (n >= 0)
            n_fed++;
        @(negedge clk);
    endtask

    // stop offering, wait for every expected code and for the byte in flight
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_codes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_escape_enable(input logic v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        esc_on     = v;
    endtask

    // a unit of back-to-back codes, escape bytes inserted as an encoder would;
    // a broken unit skips the insertion and may restart in the middle
    task automatic send_unit(input bit broken);
        bit         cw [$];
        int         n_codes;
        int         r;
        int         len;
        logic [31:0] sfx;
        logic [7:0] d;
        logic       sou;
        int         zr;
        dir_row_t   no_row;
        no_row  = '0;
        n_codes = $urandom_range(1, 12);
        for (int c = 0; c < n_codes; c++)
        begin
            r = $urandom_range(0, 99);
            if (r >= 96)
            begin
                // over-long prefix
                repeat ($urandom_range(MAX_PREFIX_DEF + 1, MAX_PREFIX_DEF + 9))
                    cw.push_back(1'b0);
                continue;
            end
            if (r < 60)
                len = $urandom_range(0, 3);
            else if (r < 85)
                len = $urandom_range(4, 10);
            else if (r < 90)
                len = MAX_PREFIX_DEF;
            else
                len = $urandom_range(11, MAX_PREFIX_DEF);
            sfx = $urandom();
            if (r % 7 == 0)
                sfx = '1;
            else if (r % 7 == 1)
                sfx = '0;
            repeat (len) cw.push_back(1'b0);
            cw.push_back(1'b1);
            for (int j = len - 1; j >= 0; j--)
                cw.push_back(sfx[j]);
        end
        while (cw.size() % 8 != 0)
            cw.push_back($urandom_range(0, 1));

        zr = 0;
        for (int i = 0; i < cw.size() / 8; i++)
        begin
            d = '0;
            for (int k = 0; k < 8; k++)
                d = {d[6:0], cw[8*i+k]};
            if (i == 0)
                sou = ($urandom_range(0, 9) != 0);
            else
                sou = broken && ($urandom_range(0, 19) == 0);
            if (sou)
                zr = 0;
            if (!broken && esc_on && zr >= 2 && d <= ESC_BYTE)
            begin
                send_item(ESC_BYTE, sou, no_row);
                sou = 1'b0;
                zr  = 0;
            end
            send_item(d, sou, no_row);
            zr = (d == 8'h00) ? zr + 1 : 0;
        end
    endtask

    // random bytes, rich in zeros and escape values
    task automatic send_noise(input int n);
        int         r;
        logic [7:0] d;
        dir_row_t   no_row;
        no_row = '0;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                d = 8'h00;
            else if (r < 42)
                d = ESC_BYTE;
            else
                d = $urandom_range(0, 255);
            send_item(d, ($urandom_range(0, 9) == 0), no_row);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int  target;
        int  r;
        bit  paused;
        paused = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table, register rewritten where the setting column changes
        for (int i = 0; i < DIR_N; i++)
        begin
            if (DIR_TABLE[i].esc != esc_on)
                write_escape_enable(DIR_TABLE[i].esc);
            send_item(DIR_TABLE[i].data, DIR_TABLE[i].sou, DIR_TABLE[i]);
        end

        // random phases over both register settings
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            write_escape_enable((ph == 1 || ph == 4 || ph == 6) ? 1'b0 : 1'b1);
            gap_max = (ph == 3) ? 0 : 6;       // one phase with no sender gaps
            if (ph == 2)
                hold_req = 1'b1;               // long hold-off, sender keeps going
            target = n_fed + PHASE_ITEMS;
            while (n_fed < target)
            begin
                if (ph == 5 && !paused && n_fed >= target - PHASE_ITEMS / 2)
                begin
                    // sender pauses until every code has come out
                    wait_idle();
                    paused = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 75)
                    send_unit(1'b0);
                else if (r < 88)
                    send_unit(1'b1);
                else
                    send_noise($urandom_range(1, 8));
            end
        end

        wait_idle();
        if (n_mismatch == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/egsd_pkg.sv
sv/egsd_bit_unit.sv
sv/egsd_ctrl.sv
sv/exp_golomb_stream_decoder.sv
sim/exp_golomb_stream_decoder_tb.sv
